// ===== rtl/cbc_pkg.sv =====
package cbc_pkg;

  // channels that answer the bus; the channel field is two bits wide
  localparam int NUM_CHANNELS = 4;
  localparam int CHAN_W       = 2;

  // control word bits
  localparam int CW_TIME_CONST_BIT = 2;  // next write is a time constant
  localparam int CW_CONTROL_BIT    = 0;  // byte is a control word, not a vector

  // item functions
  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_READ  = 2'd1;
  localparam logic [1:0] FN_RISE  = 2'd2;
  localparam logic [1:0] FN_FALL  = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic [CHAN_W-1:0] channel;
    logic [7:0]        data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       port_claimed;
    logic       terminal_count;
  } out_beat_t;

  // one counting step of a channel
  typedef struct packed {
    logic [7:0] count;
    logic       zero;
  } cnt_state_t;

endpackage

// ===== rtl/cascaded_ctc_byte_counter.sv =====
// channel  direction  handshake             payload
// in       to block   in_valid / in_stall   in_item  (func, channel, data)
// out      from block out_valid / out_stall out_item (read_data, port_claimed,
//                                                     terminal_count)
//
// every input beat gives exactly one output beat; it passes through the input
// register and then the result register
// a new beat is taken every cycle while in_stall is low; the channel cascade
// is three short decrement-and-compare steps in the single combinational pass
// rst is synchronous and clears every channel register and both valid flags
// a stall on the output holds the result register, and the input register
// then holds too, so in_stall rises only when both stages are full
module cascaded_ctc_byte_counter (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbc_pkg::in_beat_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output cbc_pkg::out_beat_t out_item
);
  import cbc_pkg::*;

  // input register
  logic     s1_valid;
  in_beat_t s1_item;
  logic     advance;

  // per-channel state
  logic [7:0] control_reg   [NUM_CHANNELS];
  logic [7:0] reload_value  [NUM_CHANNELS];
  logic [7:0] vector_reg    [NUM_CHANNELS];
  logic [7:0] count_value   [NUM_CHANNELS];
  logic       zero_flag     [NUM_CHANNELS];
  // only channel 0 is ever left high; channels 1 and 2 see whole pulses
  logic       trigger_level;

  logic [7:0] control_reg_next  [NUM_CHANNELS];
  logic [7:0] reload_value_next [NUM_CHANNELS];
  logic [7:0] vector_reg_next   [NUM_CHANNELS];
  logic [7:0] count_value_next  [NUM_CHANNELS];
  logic       zero_flag_next    [NUM_CHANNELS];
  logic       trigger_level_next;

  // cascade
  logic       is_rise;
  logic       fire0, fire1, fire2;
  cnt_state_t cur0, cur1, cur2;
  cnt_state_t nxt0, nxt1, nxt2;

  logic       chan_ok;
  out_beat_t  result;

  // ---------------------------------------------------------------------------
  // handshake: the input register moves on whenever the result register is
  // empty or being drained this cycle
  // ---------------------------------------------------------------------------
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item <= in_item;
    end
  end

  // ---------------------------------------------------------------------------
  // counting cascade: interrupt rise clocks channel 0, a set zero-count on
  // channel 0 pulses channel 1, a set zero-count on channel 1 pulses channel 2
  // ---------------------------------------------------------------------------
  assign is_rise = (s1_item.func == FN_RISE);

  assign cur0 = '{count: count_value[0], zero: zero_flag[0]};
  assign cur1 = '{count: count_value[1], zero: zero_flag[1]};
  assign cur2 = '{count: count_value[2], zero: zero_flag[2]};

  // channel 0 counts only on a low-to-high change of its trigger
  assign fire0 = is_rise && !trigger_level;
  // flag is tested whether or not it changed in this beat
  assign fire1 = is_rise && nxt0.zero;
  assign fire2 = is_rise && nxt1.zero;

  cbc_count_stage u_stage0 (
    .fire   (fire0),
    .reload (reload_value[0]),
    .cur    (cur0),
    .nxt    (nxt0)
  );

  cbc_count_stage u_stage1 (
    .fire   (fire1),
    .reload (reload_value[1]),
    .cur    (cur1),
    .nxt    (nxt1)
  );

  cbc_count_stage u_stage2 (
    .fire   (fire2),
    .reload (reload_value[2]),
    .cur    (cur2),
    .nxt    (nxt2)
  );

  // ---------------------------------------------------------------------------
  // next state and result
  // ---------------------------------------------------------------------------
  assign chan_ok = (32'(s1_item.channel) < NUM_CHANNELS);

  always_comb begin
    control_reg_next   = control_reg;
    reload_value_next  = reload_value;
    vector_reg_next    = vector_reg;
    count_value_next   = count_value;
    zero_flag_next     = zero_flag;
    trigger_level_next = trigger_level;
    result             = '0;

    case (s1_item.func)
      FN_WRITE: begin
        if (chan_ok) begin
          if (control_reg[s1_item.channel][CW_TIME_CONST_BIT]) begin
            // time constant: clear the request and load the counter
            control_reg_next[s1_item.channel][CW_TIME_CONST_BIT] = 1'b0;
            reload_value_next[s1_item.channel] = s1_item.data;
            count_value_next[s1_item.channel]  = s1_item.data;
            zero_flag_next[s1_item.channel]    = (s1_item.data == 8'd0);
          end else if (s1_item.data[CW_CONTROL_BIT]) begin
            control_reg_next[s1_item.channel] = s1_item.data;
          end else begin
            vector_reg_next[s1_item.channel] = s1_item.data;
          end
        end
      end
      FN_READ: begin
        if (chan_ok) begin
          result.read_data    = count_value[s1_item.channel];
          result.port_claimed = 1'b1;
        end
      end
      FN_RISE: begin
        count_value_next[0] = nxt0.count;
        zero_flag_next[0]   = nxt0.zero;
        count_value_next[1] = nxt1.count;
        zero_flag_next[1]   = nxt1.zero;
        count_value_next[2] = nxt2.count;
        zero_flag_next[2]   = nxt2.zero;
        trigger_level_next  = 1'b1;
      end
      FN_FALL: begin
        trigger_level_next = 1'b0;
      end
      default: begin
        trigger_level_next = trigger_level;
      end
    endcase

    // terminal count follows channel 2 zero-count after the beat
    result.terminal_count = zero_flag_next[2];
  end

  // state commits when the beat moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        control_reg[i]  <= '0;
        reload_value[i] <= '0;
        vector_reg[i]   <= '0;
        count_value[i]  <= '0;
        zero_flag[i]    <= 1'b0;
      end
      trigger_level <= 1'b0;
    end else if (advance) begin
      control_reg   <= control_reg_next;
      reload_value  <= reload_value_next;
      vector_reg    <= vector_reg_next;
      count_value   <= count_value_next;
      zero_flag     <= zero_flag_next;
      trigger_level <= trigger_level_next;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= result;
    end
  end

endmodule

// ===== rtl/cbc_count_stage.sv =====
module cbc_count_stage (
  input  logic                fire,
  input  logic [7:0]          reload,
  input  cbc_pkg::cnt_state_t cur,
  output cbc_pkg::cnt_state_t nxt
);
  import cbc_pkg::*;

  logic [7:0] dec;
  logic       hit;

  assign dec = cur.count - 8'd1;
  assign hit = (dec == 8'd0);

  // decrement with wrap, reload on reaching zero; hold between edges
  always_comb begin
    nxt = cur;
    if (fire) begin
      nxt.zero  = hit;
      nxt.count = hit ? reload : dec;
    end
  end

endmodule
